### design/edist_pkg.sv
// Shared types and constants for the edit distance block.
// No dependencies; compiled first.
`default_nettype none

package edist_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIST_W   = 7;
    localparam int unsigned DIST_SAT = 127;

    typedef enum logic [1:0] {
        MODE_CHAR_A = 2'd0,
        MODE_CHAR_B = 2'd1,
        MODE_END_A  = 2'd2,
        MODE_END_B  = 2'd3
    } t_mode;

    // Sequencer controls for the cost row unit
    typedef struct packed {
        logic row_start;
        logic cell_en;
        logic rd_en;
        logic first_row;
    } t_cell_ctl;

endpackage

`default_nettype wire

### design/edist_if.sv
// Valid/ready channel interfaces for the input beats and result beats.
// No dependencies.
`default_nettype none

interface edist_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] character;

    modport source (output valid, output mode, output character, input ready);
    modport sink   (input valid, input mode, input character, output ready);
endinterface

interface edist_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] distance;
    logic       overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

`default_nettype wire

### design/edist_strings.sv
// Character stores for both strings, one write port and registered reads.
// Depends on edist_pkg.
`default_nettype none

module edist_strings
    import edist_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64,
    parameter int unsigned AW      = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we_a,
    input  wire logic              i_we_b,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [CHAR_W-1:0] i_wr_data,
    input  wire logic              i_rd_a_en,
    input  wire logic [AW-1:0]     i_rd_a_addr,
    input  wire logic              i_rd_b_en,
    input  wire logic [AW-1:0]     i_rd_b_addr,
    output logic      [CHAR_W-1:0] o_char_a,
    output logic      [CHAR_W-1:0] o_char_b
);

    logic [CHAR_W-1:0] r_mem_a [MAX_LEN];
    logic [CHAR_W-1:0] r_mem_b [MAX_LEN];

    always_ff @(posedge i_clk) begin
        if (i_we_a) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_a_en) begin
            o_char_a <= r_mem_a[i_rd_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we_b) begin
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_b_en) begin
            o_char_b <= r_mem_b[i_rd_b_addr];
        end
    end

endmodule

`default_nettype wire

### design/edist_row.sv
// Cost row memory and the single cell unit that updates it one column per enabled cycle.
// Depends on edist_pkg.
`default_nettype none

module edist_row
    import edist_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64,
    parameter int unsigned AW      = 6,
    parameter int unsigned LW      = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [LW-1:0]     i_row_idx,
    input  wire logic [LW-1:0]     i_col,
    input  wire logic [AW-1:0]     i_rd_col,
    input  wire logic [CHAR_W-1:0] i_char_a,
    input  wire logic [CHAR_W-1:0] i_char_b,
    output logic      [LW-1:0]     o_cell
);

    // Column j of the table lives at address j-1; column 0 is implied by the row index.
    logic [LW-1:0] r_mem [MAX_LEN];
    logic [LW-1:0] r_q;
    logic [LW-1:0] r_diag;
    logic [LW-1:0] r_left;
    logic [LW-1:0] w_up;
    logic [LW-1:0] w_min_du;
    logic [LW-1:0] w_min3;

    always_comb begin
        w_up     = i_ctl.first_row ? LW'(i_col + 1'b1) : r_q;
        w_min_du = (r_diag < w_up) ? r_diag : w_up;
        w_min3   = (w_min_du < r_left) ? w_min_du : r_left;
        o_cell   = (i_char_a == i_char_b) ? r_diag : LW'(w_min3 + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cell_en) begin
            r_mem[i_col[AW-1:0]] <= o_cell;
        end
        if (i_ctl.rd_en) begin
            r_q <= r_mem[i_rd_col];
        end
    end

    // Seed diagonal and left from column 0, then slide them along the row
    always_ff @(posedge i_clk) begin
        if (i_ctl.row_start) begin
            r_diag <= i_row_idx;
            r_left <= LW'(i_row_idx + 1'b1);
        end else if (i_ctl.cell_en) begin
            r_diag <= w_up;
            r_left <= o_cell;
        end
    end

    logic [31:0] e_diag;
    logic [31:0] e_left;
    logic [31:0] e_up;
    logic [31:0] e_cell;

    assign e_diag = 32'(r_diag);
    assign e_left = 32'(r_left);
    assign e_up   = 32'(w_up);
    assign e_cell = 32'(o_cell);

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.rd_en && i_ctl.cell_en && (i_rd_col == i_col[AW-1:0])))
        else $error("row read and write hit the same entry");

    a_diag_left_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.cell_en |-> (e_left <= e_diag + 1) && (e_diag <= e_left + 1))
        else $error("vertically adjacent costs differ by more than one");

    a_cell_up_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.cell_en |-> (e_cell <= e_up + 1) && (e_up <= e_cell + 1))
        else $error("new cost differs from the one above by more than one");

endmodule

`default_nettype wire

### design/edit_distance.sv
// Edit distance block: loads two byte strings beat by beat, then computes the
// Levenshtein distance (unit costs) with a sequencer over a cost row memory.
// Depends on edist_pkg, edist_if, edist_strings and edist_row.
//
// Character beats (mode 0 or 1) and end-of-first-string beats are taken while the
// block is idle; characters beyond MAX_LEN are dropped and flag overflow on the
// next result. An end-of-second-string beat with both lengths nonzero starts the
// table fill: the single cell unit reads and rewrites one cost row entry per cycle,
// and each row opens with a step that fetches its character of the first string;
// the last cost is then registered as the result. If either string is empty the
// fill is skipped and the other length goes straight to the emit step. Input is
// held off during the fill and until the result moves into the output register;
// the result then sits there, so loading of the next pair continues while it waits.
// Distances above 127 saturate. The stores need no clearing after reset.
`default_nettype none

module edit_distance
    import edist_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    edist_in_if.sink    i_in,
    edist_out_if.source o_out
);

    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned LW = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_CELL,
        S_EMIT
    } t_state;

    t_state        r_state;
    logic [LW-1:0] r_len_a;
    logic [LW-1:0] r_len_b;
    logic          r_ovf_seen;
    logic [LW-1:0] r_i;
    logic [LW-1:0] r_j;
    logic [LW-1:0] r_result;
    logic          r_out_valid;
    logic [DIST_W-1:0] r_dist;
    logic          r_ovf;

    logic          w_accept;
    t_mode         w_mode;
    logic          w_room_a;
    logic          w_room_b;
    logic          w_last_col;
    logic          w_last_row;
    logic          w_emit;
    logic [31:0]   w_res_ext;
    logic [DIST_W-1:0] w_dist_sat;
    logic [AW-1:0] w_rd_col;
    t_cell_ctl     w_ctl;
    logic [CHAR_W-1:0] w_char_a;
    logic [CHAR_W-1:0] w_char_b;
    logic [LW-1:0] w_cell;

    assign i_in.ready     = (r_state == S_IDLE);
    assign w_accept       = i_in.valid && i_in.ready;
    assign w_mode         = t_mode'(i_in.mode);
    assign w_room_a       = (r_len_a < LW'(MAX_LEN));
    assign w_room_b       = (r_len_b < LW'(MAX_LEN));
    assign w_last_col     = (r_j == LW'(r_len_b - 1'b1));
    assign w_last_row     = (r_i == LW'(r_len_a - 1'b1));
    assign w_emit         = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign w_res_ext      = 32'(r_result);
    assign w_dist_sat     = (w_res_ext > 32'(DIST_SAT)) ? DIST_W'(DIST_SAT)
                                                        : w_res_ext[DIST_W-1:0];

    assign o_out.valid    = r_out_valid;
    assign o_out.distance = r_dist;
    assign o_out.overflow = r_ovf;

    // Next column to fetch: column 1 at row start, else the one after the current
    assign w_rd_col = (r_state == S_ROW) ? '0 : AW'(r_j + 1'b1);

    always_comb begin
        w_ctl.row_start = (r_state == S_ROW);
        w_ctl.cell_en   = (r_state == S_CELL);
        w_ctl.rd_en     = (r_state == S_ROW) || ((r_state == S_CELL) && !w_last_col);
        w_ctl.first_row = (r_i == '0);
    end

    edist_strings #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW)
    ) u_strings (
        .i_clk       (i_clk),
        .i_we_a      (w_accept && (w_mode == MODE_CHAR_A) && w_room_a),
        .i_we_b      (w_accept && (w_mode == MODE_CHAR_B) && w_room_b),
        .i_wr_addr   ((w_mode == MODE_CHAR_A) ? r_len_a[AW-1:0] : r_len_b[AW-1:0]),
        .i_wr_data   (i_in.character),
        .i_rd_a_en   (w_ctl.row_start),
        .i_rd_a_addr (r_i[AW-1:0]),
        .i_rd_b_en   (w_ctl.rd_en),
        .i_rd_b_addr (w_rd_col),
        .o_char_a    (w_char_a),
        .o_char_b    (w_char_b)
    );

    edist_row #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .LW      (LW)
    ) u_row (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_row_idx (r_i),
        .i_col     (r_j),
        .i_rd_col  (w_rd_col),
        .i_char_a  (w_char_a),
        .i_char_b  (w_char_b),
        .o_cell    (w_cell)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_ovf_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_mode)
                            MODE_CHAR_A: begin
                                if (w_room_a) begin
                                    r_len_a <= LW'(r_len_a + 1'b1);
                                end else begin
                                    r_ovf_seen <= 1'b1;
                                end
                            end
                            MODE_CHAR_B: begin
                                if (w_room_b) begin
                                    r_len_b <= LW'(r_len_b + 1'b1);
                                end else begin
                                    r_ovf_seen <= 1'b1;
                                end
                            end
                            MODE_END_B: begin
                                r_i <= '0;
                                if ((r_len_a == '0) || (r_len_b == '0)) begin
                                    // one side empty: distance is the other length
                                    r_result <= LW'(r_len_a + r_len_b);
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_state <= S_ROW;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ROW: begin
                    r_j     <= '0;
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    if (w_last_col) begin
                        if (w_last_row) begin
                            r_result <= w_cell;
                            r_state  <= S_EMIT;
                        end else begin
                            r_i     <= LW'(r_i + 1'b1);
                            r_state <= S_ROW;
                        end
                    end else begin
                        r_j <= LW'(r_j + 1'b1);
                    end
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (w_emit) begin
                        r_out_valid <= 1'b1;
                        r_dist      <= w_dist_sat;
                        r_ovf       <= r_ovf_seen;
                        r_len_a     <= '0;
                        r_len_b     <= '0;
                        r_ovf_seen  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len_a <= LW'(MAX_LEN)) && (r_len_b <= LW'(MAX_LEN)))
        else $error("string length beyond store depth");

    a_cell_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |-> (r_i < r_len_a) && (r_j < r_len_b))
        else $error("cell index outside the stored strings");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result beat raised outside the emit step");

endmodule

`default_nettype wire

### sim/edist_checker.sv
// Result checker for the edit distance block: keeps its own copy of both strings,
// predicts each result on the end-of-second-string beat, and compares result beats.
// Depends on edist_pkg.
`default_nettype none

module edist_checker
    import edist_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic [1:0]        i_in_mode,
    input  wire logic [CHAR_W-1:0] i_in_character,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [DIST_W-1:0] i_out_distance,
    input  wire logic              i_out_overflow,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_edist_result;

    logic [CHAR_W-1:0] str_a [MAX_LEN];
    logic [CHAR_W-1:0] str_b [MAX_LEN];
    int                len_a;
    int                len_b;
    logic              dropped_char;
    t_edist_result     results_due[$];
    int                fail_count = 0;

    // Row-by-row fill of the cost table over the stored strings
    function automatic logic [DIST_W-1:0] edit_cost();
        int unsigned row [MAX_LEN+1];
        int unsigned diag;
        int unsigned up;
        int unsigned cost;
        int unsigned total;
        for (int j = 0; j <= len_b; j++) row[j] = j;
        for (int i = 1; i <= len_a; i++) begin
            diag   = row[0];
            row[0] = i;
            for (int j = 1; j <= len_b; j++) begin
                up = row[j];
                if (str_a[i-1] == str_b[j-1]) begin
                    cost = diag;
                end else begin
                    cost = diag;
                    if (up < cost) cost = up;
                    if (row[j-1] < cost) cost = row[j-1];
                    cost = cost + 1;
                end
                diag   = up;
                row[j] = cost;
            end
        end
        total = row[len_b];
        return (total > DIST_SAT) ? DIST_W'(DIST_SAT) : DIST_W'(total);
    endfunction

    always @(posedge i_clk) begin
        t_edist_result want;
        if (!i_rst_n) begin
            len_a        = 0;
            len_b        = 0;
            dropped_char = 1'b0;
        end else begin
            // Retire the result beat first: it can never belong to this edge's input beat
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result beat with none due: distance %0d overflow %0d",
                           i_out_distance, i_out_overflow);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (i_out_distance !== want.distance) begin
                        $error("distance mismatch: expected %0d, actual %0d",
                               want.distance, i_out_distance);
                        fail_count++;
                    end
                    if (i_out_overflow !== want.overflow) begin
                        $error("overflow mismatch: expected %0d, actual %0d",
                               want.overflow, i_out_overflow);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (t_mode'(i_in_mode))
                    MODE_CHAR_A: begin
                        if (len_a < MAX_LEN) begin
                            str_a[len_a] = i_in_character;
                            len_a++;
                        end else begin
                            dropped_char = 1'b1;
                        end
                    end
                    MODE_CHAR_B: begin
                        if (len_b < MAX_LEN) begin
                            str_b[len_b] = i_in_character;
                            len_b++;
                        end else begin
                            dropped_char = 1'b1;
                        end
                    end
                    MODE_END_A: begin
                    end
                    MODE_END_B: begin
                        results_due.push_back('{distance: edit_cost(), overflow: dropped_char});
                        len_a        = 0;
                        len_b        = 0;
                        dropped_char = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= results_due.size();
    end

endmodule

`default_nettype wire

### sim/tb_edit_distance.sv
// Top of the edit distance testbench: clock, reset, string pair stimulus with
// bursty input and a stalling result receiver, watchdog and verdict.
// Depends on edist_pkg, edist_if, edit_distance and edist_checker.
`default_nettype none

module tb_edit_distance;
    timeunit 1ns;
    timeprecision 1ps;

    import edist_pkg::*;

    localparam int unsigned MAX_LEN     = 64;
    localparam int          TOTAL_BEATS = 700;
    localparam int          HOLD_CYCLES = 600;
    localparam int          QUIET_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    edist_in_if  in_ch ();
    edist_out_if out_ch ();

    int   fail_count;
    int   pending;
    int   beats_sent;
    int   burst_left;
    int   quiet_cycles = 0;
    logic hold_req;

    logic [CHAR_W-1:0] pair_a[$];
    logic [CHAR_W-1:0] pair_b[$];

    edit_distance #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    edist_checker #(
        .MAX_LEN(MAX_LEN)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_mode     (in_ch.mode),
        .i_in_character(in_ch.character),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_distance(out_ch.distance),
        .i_out_overflow(out_ch.overflow),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Called and returns at a falling edge; bursts of beats with random gaps
    task automatic send_beat(input t_mode mode, input logic [CHAR_W-1:0] character);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.character <= character;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        beats_sent++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char(input bit narrow);
        return narrow ? 8'h61 + CHAR_W'($urandom_range(0, 3)) : CHAR_W'($urandom_range(0, 255));
    endfunction

    // Short pair; the second string is often an edited copy of the first
    task automatic make_pair(input int len_a, input bit related, input bit narrow);
        pair_a.delete();
        pair_b.delete();
        repeat (len_a) pair_a.push_back(pick_char(narrow));
        if (related) begin
            foreach (pair_a[k]) begin
                case ($urandom_range(0, 9))
                    0: begin
                    end
                    1: pair_b.push_back(pick_char(narrow));
                    2: begin
                        pair_b.push_back(pair_a[k]);
                        pair_b.push_back(pick_char(narrow));
                    end
                    default: pair_b.push_back(pair_a[k]);
                endcase
            end
        end else begin
            repeat ($urandom_range(0, 8)) pair_b.push_back(pick_char(narrow));
        end
    endtask

    // Long pair over the full byte range; second copies or inverts the first, then random
    task automatic make_long(input int len_a, input int len_b, input bit invert);
        pair_a.delete();
        pair_b.delete();
        repeat (len_a) pair_a.push_back(pick_char(1'b0));
        for (int k = 0; k < len_b; k++) begin
            if (k < len_a) pair_b.push_back(invert ? ~pair_a[k] : pair_a[k]);
            else pair_b.push_back(pick_char(1'b0));
        end
    endtask

    task automatic send_pair(input int style);
        int ia;
        int ib;
        ia = 0;
        ib = 0;
        case (style)
            0: begin
                foreach (pair_a[k]) send_beat(MODE_CHAR_A, pair_a[k]);
                send_beat(MODE_END_A, pick_char(1'b0));
                foreach (pair_b[k]) send_beat(MODE_CHAR_B, pair_b[k]);
            end
            1: begin
                foreach (pair_b[k]) send_beat(MODE_CHAR_B, pair_b[k]);
                foreach (pair_a[k]) send_beat(MODE_CHAR_A, pair_a[k]);
            end
            default: begin
                // Interleave both strings, with stray end-of-first markers
                while (ia < pair_a.size() || ib < pair_b.size()) begin
                    if ($urandom_range(0, 7) == 0) send_beat(MODE_END_A, pick_char(1'b0));
                    if (ib >= pair_b.size() || (ia < pair_a.size() && $urandom_range(0, 1))) begin
                        send_beat(MODE_CHAR_A, pair_a[ia]);
                        ia++;
                    end else begin
                        send_beat(MODE_CHAR_B, pair_b[ib]);
                        ib++;
                    end
                end
            end
        endcase
        send_beat(MODE_END_B, pick_char(1'b0));
    endtask

    // Result receiver: stall phases of varying density, one long hold-off on request
    initial begin
        int  stall_pct;
        int  phase_left;
        bit  hold_done;
        out_ch.ready = 1'b0;
        stall_pct    = 0;
        phase_left   = 0;
        hold_done    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            phase_left--;
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int pair_no;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_CHAR_A;
        in_ch.character = '0;
        i_rst_n         = 1'b0;
        hold_req        = 1'b0;
        burst_left      = 0;
        beats_sent      = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Both strings empty
        send_beat(MODE_END_B, 8'h00);
        // First string only, second empty
        send_beat(MODE_CHAR_A, 8'hFF);
        send_beat(MODE_END_A, 8'hFF);
        send_beat(MODE_END_B, 8'hFF);
        // Second string only, first empty
        send_beat(MODE_CHAR_B, 8'h00);
        send_beat(MODE_END_B, 8'h00);
        // Extreme bytes, swapped order
        send_beat(MODE_CHAR_A, 8'h00);
        send_beat(MODE_CHAR_A, 8'hFF);
        send_beat(MODE_END_A, 8'h00);
        send_beat(MODE_CHAR_B, 8'hFF);
        send_beat(MODE_CHAR_B, 8'h00);
        send_beat(MODE_END_B, 8'h00);
        // First string keeps growing after its end marker
        send_beat(MODE_CHAR_A, 8'h6B);
        send_beat(MODE_END_A, 8'h00);
        send_beat(MODE_CHAR_A, 8'h78);
        send_beat(MODE_CHAR_B, 8'h6B);
        send_beat(MODE_CHAR_B, 8'h78);
        send_beat(MODE_END_B, 8'hAA);
        // Single replace, second string loaded before the end marker
        send_beat(MODE_CHAR_A, 8'h55);
        send_beat(MODE_CHAR_B, 8'hAA);
        send_beat(MODE_END_A, 8'h55);
        send_beat(MODE_END_B, 8'h55);

        pair_no = 0;
        while (beats_sent < TOTAL_BEATS) begin
            if (pair_no == 8) hold_req <= 1'b1;
            case (pair_no)
                5:  make_long(MAX_LEN, MAX_LEN, 1'b1);
                14: make_long(MAX_LEN + 3, MAX_LEN + 2, 1'b0);
                22: make_long(MAX_LEN + 2, 1, 1'b0);
                30: make_long(2, MAX_LEN + 1, 1'b0);
                default: begin
                    // Occasional noise: loose beats of any mode
                    if ($urandom_range(0, 9) == 0) begin
                        repeat ($urandom_range(1, 6))
                            send_beat(t_mode'($urandom_range(0, 3)), pick_char(1'b0));
                    end
                    make_pair($urandom_range(0, 8), $urandom_range(0, 1),
                              $urandom_range(0, 3) != 0);
                end
            endcase
            send_pair($urandom_range(0, 3));
            pair_no++;
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
